// ----- sv/swsp_pkg.sv -----
// Shared types and constants for the swept-sphere pair prune block.
// Used by every module of the block but swsp_ram; depends on nothing.
`timescale 1ns / 1ps

package swsp_pkg;

    // Field widths of the stream beats and registers
    localparam int IDX_W       = 10;
    localparam int COORD_W     = 32;
    localparam int RAD_W       = 31;
    localparam int LANE_W      = 3;
    localparam int CNT_W       = 11;
    localparam int STEP_W      = 16;
    localparam int SKIN_W      = 31;
    localparam int THR_W       = 63;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 63;
    localparam int IN_TDATA_W  = 248;
    localparam int OUT_TDATA_W = 8;

    localparam int DEF_MAX_BODIES = 1024;

    // Input tdata bit offsets, lowest first
    localparam int OFF_IDX_A = 0;
    localparam int OFF_IDX_B = 10;
    localparam int OFF_POS_X = 20;
    localparam int OFF_POS_Y = 52;
    localparam int OFF_POS_Z = 84;
    localparam int OFF_VEL_X = 116;
    localparam int OFF_VEL_Y = 148;
    localparam int OFF_VEL_Z = 180;
    localparam int OFF_RAD   = 212;
    localparam int OFF_BAD   = 243;
    localparam int OFF_LANE  = 244;

    // Datapath widths
    localparam int S_W    = 33;   // relative start, Q16.16
    localparam int M_W    = 34;   // relative motion, Q16.16
    localparam int MOT_W  = 50;   // motion product before rounding
    localparam int MSQ_W  = 68;   // square / dot term
    localparam int LEN_W  = 67;   // |m|^2
    localparam int DOT_W  = 68;   // dot(s,m), signed
    localparam int REM_W  = 68;   // divider remainder
    localparam int T_W    = 17;   // Q0.16 with room for 1.0
    localparam int CT_W   = 52;   // m * t product
    localparam int C_W    = 36;   // closest point
    localparam int CSQ_W  = 72;
    localparam int DIST_W = 74;
    localparam int R_W    = 33;
    localparam int R2_W   = 66;
    localparam int RSH    = 16;   // Q16 rounding shift

    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    // Sequencing
    localparam int AXES       = 3;
    localparam int AXIS_W     = 2;
    localparam int DIV_STEPS  = 16;
    localparam int STEP_CNT_W = 4;

    // Register reset values
    localparam logic [CNT_W-1:0]  RST_BODY_COUNT = '0;
    localparam logic [STEP_W-1:0] RST_STEP_TIME  = STEP_W'(1092);
    localparam logic [SKIN_W-1:0] RST_SKIN       = '0;
    localparam logic [THR_W-1:0]  RST_STILL_THR  = THR_W'(1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BODY_COUNT   = 2'd0,
        REG_STEP_TIME    = 2'd1,
        REG_CONTACT_SKIN = 2'd2,
        REG_STILL_THR    = 2'd3
    } cfg_reg_t;

    // One body record as held in the table
    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] vel_x;
        logic signed [COORD_W-1:0] vel_y;
        logic signed [COORD_W-1:0] vel_z;
        logic [RAD_W-1:0]          radius;
        logic                      radius_bad;
    } body_rec_t;

    // Controller to datapath
    typedef struct packed {
        logic              load;
        logic              capture;
        logic              rd_b;
        logic              latch_a;
        logic              diff;
        logic              motion;
        logic              lensq;
        logic              dotp;
        logic              decide;
        logic              div_step;
        logic              closest;
        logic              distsq;
        logic              radsq;
        logic              finish;
        logic [AXIS_W-1:0] axis;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic skip_div;
        logic out_full;
    } dp_status_t;

endpackage

// ----- sv/swsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module swsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/swsp_ctrl.sv -----
// Sequencer for the pair test: table reads, per-axis passes, division, result.
// Depends on swsp_pkg.
`timescale 1ns / 1ps

module swsp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,
    output swsp_pkg::dp_cmd_t     cmd,
    input  swsp_pkg::dp_status_t  status
);
    import swsp_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_RD_A    = 13'b0000000000010,
        ST_RD_B    = 13'b0000000000100,
        ST_DIFF    = 13'b0000000001000,
        ST_MOTION  = 13'b0000000010000,
        ST_LENSQ   = 13'b0000000100000,
        ST_DOTP    = 13'b0000001000000,
        ST_DECIDE  = 13'b0000010000000,
        ST_DIVIDE  = 13'b0000100000000,
        ST_CLOSEST = 13'b0001000000000,
        ST_DISTSQ  = 13'b0010000000000,
        ST_RADSQ   = 13'b0100000000000,
        ST_FINISH  = 13'b1000000000000
    } state_t;

    state_t                state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  last_axis, last_div, accept;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign last_axis = (cnt_reg == STEP_CNT_W'(AXES - 1));
    assign last_div  = (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1));

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.axis   = cnt_reg[AXIS_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load    = accept && !s_tuser;
                cmd.capture = accept && s_tuser;
                if (accept && s_tuser)
                begin
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A:
            begin
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                cmd.rd_b    = 1'b1;
                cmd.latch_a = 1'b1;
                state_next  = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                cnt_next   = '0;
                state_next = ST_MOTION;
            end
            ST_MOTION:
            begin
                cmd.motion = 1'b1;
                cnt_next   = last_axis ? '0 : cnt_reg + 1'b1;
                state_next = last_axis ? ST_LENSQ : ST_MOTION;
            end
            ST_LENSQ:
            begin
                cmd.lensq  = 1'b1;
                cnt_next   = last_axis ? '0 : cnt_reg + 1'b1;
                state_next = last_axis ? ST_DOTP : ST_LENSQ;
            end
            ST_DOTP:
            begin
                cmd.dotp   = 1'b1;
                cnt_next   = last_axis ? '0 : cnt_reg + 1'b1;
                state_next = last_axis ? ST_DECIDE : ST_DOTP;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                cnt_next   = '0;
                state_next = status.skip_div ? ST_CLOSEST : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = last_div ? '0 : cnt_reg + 1'b1;
                state_next   = last_div ? ST_CLOSEST : ST_DIVIDE;
            end
            ST_CLOSEST:
            begin
                cmd.closest = 1'b1;
                cnt_next    = last_axis ? '0 : cnt_reg + 1'b1;
                state_next  = last_axis ? ST_DISTSQ : ST_CLOSEST;
            end
            ST_DISTSQ:
            begin
                cmd.distsq = 1'b1;
                cnt_next   = last_axis ? '0 : cnt_reg + 1'b1;
                state_next = last_axis ? ST_RADSQ : ST_DISTSQ;
            end
            ST_RADSQ:
            begin
                cmd.radsq  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register can take the result
                if (!status.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Checks
    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && !status.out_full |=> state_reg == ST_IDLE)
        else $error("finish did not return to idle");

    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DECIDE && !status.skip_div |=>
            state_reg == ST_DIVIDE && cnt_reg == '0)
        else $error("division not entered cleanly");

    a_cnt_scope: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 |-> state_reg == ST_MOTION || state_reg == ST_LENSQ ||
            state_reg == ST_DOTP || state_reg == ST_DIVIDE ||
            state_reg == ST_CLOSEST || state_reg == ST_DISTSQ)
        else $error("step counter running outside a looping state");

endmodule

// ----- sv/swsp_dp.sv -----
// Datapath: body table, relative geometry, restoring divider, result register.
// Depends on swsp_pkg and swsp_ram.
`timescale 1ns / 1ps

module swsp_dp #(
    parameter int MAX_BODIES = swsp_pkg::DEF_MAX_BODIES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  swsp_pkg::dp_cmd_t                  cmd,
    output swsp_pkg::dp_status_t               status,
    input  logic [swsp_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [swsp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic [swsp_pkg::CNT_W-1:0]         body_count,
    input  logic [swsp_pkg::STEP_W-1:0]        step_time,
    input  logic [swsp_pkg::SKIN_W-1:0]        contact_skin,
    input  logic [swsp_pkg::THR_W-1:0]         still_thr
);
    import swsp_pkg::*;

    localparam int ADDR_W = $clog2(MAX_BODIES);
    localparam int REC_W  = $bits(body_rec_t);

    logic [IDX_W-1:0]  in_a, in_b;
    logic              a_in_table, b_in_table, in_range_now;
    body_rec_t         wr_rec, rd_rec, rec_a_reg;
    logic [REC_W-1:0]  rd_bits;
    logic [ADDR_W-1:0] addr_a_reg, addr_b_reg, raddr;
    logic [LANE_W-1:0] lane_reg;
    logic              in_range_reg;

    logic signed [COORD_W-1:0] a_pos [AXES];
    logic signed [COORD_W-1:0] b_pos [AXES];
    logic signed [COORD_W-1:0] a_vel [AXES];
    logic signed [COORD_W-1:0] b_vel [AXES];

    logic signed [S_W-1:0] s_reg  [AXES];
    logic signed [S_W-1:0] dv_reg [AXES];
    logic signed [M_W-1:0] m_reg  [AXES];
    logic signed [C_W-1:0] c_reg  [AXES];

    logic [LEN_W-1:0]        len_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [T_W-1:0]          t_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic [R_W-1:0]          r_reg;
    logic [R2_W-1:0]         r2_reg;
    logic                    bad_reg;

    logic signed [MOT_W-1:0] mot_prod;
    logic signed [MSQ_W-1:0] m_sq, sm_prod;
    logic signed [CT_W-1:0]  ct_prod;
    logic signed [CSQ_W-1:0] c_sq;
    logic                    still, dot_neg, div_full;
    logic [REM_W-1:0]        num, rem_sh, len_ext;

    logic              out_valid_reg;
    logic [LANE_W-1:0] out_lane_reg;
    logic              out_accepted_reg, out_in_range_reg;

    // Fields of the incoming beat
    assign in_a = s_tdata[OFF_IDX_A +: IDX_W];
    assign in_b = s_tdata[OFF_IDX_B +: IDX_W];
    assign wr_rec.pos_x      = s_tdata[OFF_POS_X +: COORD_W];
    assign wr_rec.pos_y      = s_tdata[OFF_POS_Y +: COORD_W];
    assign wr_rec.pos_z      = s_tdata[OFF_POS_Z +: COORD_W];
    assign wr_rec.vel_x      = s_tdata[OFF_VEL_X +: COORD_W];
    assign wr_rec.vel_y      = s_tdata[OFF_VEL_Y +: COORD_W];
    assign wr_rec.vel_z      = s_tdata[OFF_VEL_Z +: COORD_W];
    assign wr_rec.radius     = s_tdata[OFF_RAD +: RAD_W];
    assign wr_rec.radius_bad = s_tdata[OFF_BAD];

    assign a_in_table   = 32'(in_a) < 32'(MAX_BODIES);
    assign b_in_table   = 32'(in_b) < 32'(MAX_BODIES);
    assign in_range_now = a_in_table && b_in_table &&
                          (CNT_W'(in_a) < body_count) && (CNT_W'(in_b) < body_count);

    // Body table
    assign raddr = cmd.rd_b ? addr_b_reg : addr_a_reg;

    swsp_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_BODIES)
    ) u_table (
        .clk   (clk),
        .we    (cmd.load && a_in_table),
        .waddr (ADDR_W'(in_a)),
        .wdata (wr_rec),
        .raddr (raddr),
        .rdata (rd_bits)
    );

    assign rd_rec = body_rec_t'(rd_bits);

    // Per-axis views of body a (latched) and body b (read data)
    assign a_pos[0] = rec_a_reg.pos_x;
    assign a_pos[1] = rec_a_reg.pos_y;
    assign a_pos[2] = rec_a_reg.pos_z;
    assign a_vel[0] = rec_a_reg.vel_x;
    assign a_vel[1] = rec_a_reg.vel_y;
    assign a_vel[2] = rec_a_reg.vel_z;
    assign b_pos[0] = rd_rec.pos_x;
    assign b_pos[1] = rd_rec.pos_y;
    assign b_pos[2] = rd_rec.pos_z;
    assign b_vel[0] = rd_rec.vel_x;
    assign b_vel[1] = rd_rec.vel_y;
    assign b_vel[2] = rd_rec.vel_z;

    // One multiplier per pass, axis chosen by the controller
    assign mot_prod = MOT_W'(dv_reg[cmd.axis]) * MOT_W'($signed({1'b0, step_time}));
    assign m_sq     = MSQ_W'(m_reg[cmd.axis]) * MSQ_W'(m_reg[cmd.axis]);
    assign sm_prod  = MSQ_W'(s_reg[cmd.axis]) * MSQ_W'(m_reg[cmd.axis]);
    assign ct_prod  = CT_W'(m_reg[cmd.axis]) * CT_W'($signed({1'b0, t_reg}));
    assign c_sq     = CSQ_W'(c_reg[cmd.axis]) * CSQ_W'(c_reg[cmd.axis]);

    // Step time choice: zero if out of range, still or moving apart, one if past the end
    assign len_ext  = REM_W'(len_reg);
    assign still    = len_reg <= LEN_W'(still_thr);
    assign dot_neg  = dot_reg[DOT_W-1];
    assign num      = REM_W'(-dot_reg);
    assign div_full = len_ext <= num;
    assign rem_sh   = {rem_reg[REM_W-2:0], 1'b0};

    // an out-of-range pair never needs the divide, whatever the table holds
    assign status.skip_div = !in_range_reg || still || !dot_neg || div_full;
    assign status.out_full = out_valid_reg && !m_tready;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_a_reg   <= ADDR_W'(in_a);
            addr_b_reg   <= ADDR_W'(in_b);
            lane_reg     <= s_tdata[OFF_LANE +: LANE_W];
            in_range_reg <= in_range_now;
        end
        if (cmd.latch_a)
        begin
            rec_a_reg <= rd_rec;
        end
        if (cmd.diff)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                s_reg[i]  <= S_W'(a_pos[i]) - S_W'(b_pos[i]);
                dv_reg[i] <= S_W'(a_vel[i]) - S_W'(b_vel[i]);
            end
            r_reg    <= R_W'(rec_a_reg.radius) + R_W'(rd_rec.radius) + R_W'(contact_skin);
            bad_reg  <= rec_a_reg.radius_bad || rd_rec.radius_bad;
            len_reg  <= '0;
            dot_reg  <= '0;
            dist_reg <= '0;
        end
        if (cmd.motion)
        begin
            m_reg[cmd.axis] <= M_W'(mot_prod >>> RSH);
        end
        if (cmd.lensq)
        begin
            len_reg <= len_reg + LEN_W'($unsigned(m_sq));
        end
        if (cmd.dotp)
        begin
            dot_reg <= dot_reg + DOT_W'(sm_prod);
        end
        if (cmd.decide)
        begin
            rem_reg <= num;
            t_reg   <= (in_range_reg && !still && dot_neg && div_full) ? T_ONE : '0;
        end
        // restoring divide, one quotient bit per cycle
        if (cmd.div_step)
        begin
            if (len_ext <= rem_sh)
            begin
                rem_reg <= rem_sh - len_ext;
                t_reg   <= {t_reg[T_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                t_reg   <= {t_reg[T_W-2:0], 1'b0};
            end
        end
        if (cmd.closest)
        begin
            c_reg[cmd.axis] <= C_W'(s_reg[cmd.axis]) + C_W'(ct_prod >>> RSH);
        end
        if (cmd.distsq)
        begin
            dist_reg <= dist_reg + DIST_W'($unsigned(c_sq));
        end
        if (cmd.radsq)
        begin
            r2_reg <= R2_W'(r_reg) * R2_W'(r_reg);
        end
        if (cmd.finish)
        begin
            out_lane_reg     <= lane_reg;
            out_in_range_reg <= in_range_reg;
            out_accepted_reg <= in_range_reg && (bad_reg || dist_reg <= DIST_W'(r2_reg));
        end
    end

    // Output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_in_range_reg, out_accepted_reg, out_lane_reg});

    // Checks
    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("result not presented after finish");

    a_t_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.closest |-> t_reg <= T_ONE)
        else $error("step time above one");

    a_range_gates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_in_range_reg |-> !out_accepted_reg)
        else $error("out-of-range pair accepted");

endmodule

// ----- sv/swept_sphere_pair_prune.sv -----
// Swept-sphere pair prune: top level, configuration registers and hookup.
// Depends on swsp_pkg, swsp_ctrl and swsp_dp.
//
// Load beats (tuser = 0) write one body record into the table and give no
// result. Test beats (tuser = 1) take one body pair through a sequencer:
// two table reads, per-axis passes over one shared multiplier slot each,
// a restoring divide for the closest-approach time, then the distance test.
// The divide is skipped when the pair is still, moving apart, out of range
// or reaches its closest point at or past the tick end. The sequencer is
// back in idle in the same cycle as the result appears, so the next beat
// can be taken then; a result that waits on a stalled output holds the
// sequencer in its final state. Input is taken only while the sequencer is
// idle; one finished result may sit in the output register while the next
// beat is accepted.
// The table is not cleared on reset: load every body below body_count
// before testing it.
`timescale 1ns / 1ps

module swept_sphere_pair_prune #(
    parameter int MAX_BODIES = swsp_pkg::DEF_MAX_BODIES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // index_a, index_b, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    // bound_radius, radius_bad, lane, zero pad
    input  logic [swsp_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tuser,   // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // lane_out, accepted, in_range, zero pad
    output logic [swsp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_we,
    input  logic [swsp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [swsp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import swsp_pkg::*;

    logic [CNT_W-1:0]  body_count_reg;
    logic [STEP_W-1:0] step_time_reg;
    logic [SKIN_W-1:0] skin_reg;
    logic [THR_W-1:0]  still_thr_reg;
    dp_cmd_t           cmd;
    dp_status_t        status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_count_reg <= RST_BODY_COUNT;
            step_time_reg  <= RST_STEP_TIME;
            skin_reg       <= RST_SKIN;
            still_thr_reg  <= RST_STILL_THR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_BODY_COUNT:   body_count_reg <= cfg_wdata[CNT_W-1:0];
                REG_STEP_TIME:    step_time_reg  <= cfg_wdata[STEP_W-1:0];
                REG_CONTACT_SKIN: skin_reg       <= cfg_wdata[SKIN_W-1:0];
                REG_STILL_THR:    still_thr_reg  <= cfg_wdata[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    swsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    swsp_dp #(
        .MAX_BODIES (MAX_BODIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .body_count   (body_count_reg),
        .step_time    (step_time_reg),
        .contact_skin (skin_reg),
        .still_thr    (still_thr_reg)
    );

endmodule
